// ----- sv/ddrs_pkg.sv -----
// Shared types and constants of the dual deploy recovery sequencer.
package ddrs_pkg;

   localparam int ALT_W     = 20;
   localparam int PITCH_W   = 12;
   localparam int CFG_ALT_W = 19;
   localparam int MARGIN_W  = 16;
   localparam int COUNT_W   = 8;
   localparam int PHASE_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_IDX_W-1:0] REG_ARM_ALTITUDE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DROP_MARGIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAIN_ALTITUDE = 3'd5;

   localparam logic [CFG_ALT_W-1:0]       RST_ARM_ALTITUDE  = 19'd10000;
   localparam logic signed [PITCH_W-1:0]  RST_PITCH_MIN     = 12'sd600;
   localparam logic signed [PITCH_W-1:0]  RST_PITCH_MAX     = 12'sd1200;
   localparam logic [MARGIN_W-1:0]        RST_DROP_MARGIN   = 16'd30;
   localparam logic [COUNT_W-1:0]         RST_CONFIRM_COUNT = 8'd3;
   localparam logic [CFG_ALT_W-1:0]       RST_MAIN_ALTITUDE = 19'd6000;

   localparam logic [PHASE_W-1:0] PHASE_CODE_CLIMB   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_DESCENT = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_MAIN    = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLIMB   = 3'b001,
      ST_DESCENT = 3'b010,
      ST_MAIN    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CFG_ALT_W-1:0]      arm_altitude;
      logic signed [PITCH_W-1:0] pitch_min;
      logic signed [PITCH_W-1:0] pitch_max;
      logic [MARGIN_W-1:0]       drop_margin;
      logic [COUNT_W-1:0]        confirm_count;
      logic [CFG_ALT_W-1:0]      main_altitude;
   } cfg_type;

   typedef struct packed {
      logic                      valid;
      logic signed [ALT_W-1:0]   altitude;
      logic signed [PITCH_W-1:0] pitch;
   } stage_type;

endpackage

// ----- sv/ddrs_if.sv -----
// Valid/ready channel interfaces for the request and response words.
interface ddrs_req_if;
   import ddrs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ALT_W-1:0]   altitude;
   logic signed [PITCH_W-1:0] pitch;
   modport source (output valid, output altitude, output pitch, input ready);
   modport sink (input valid, input altitude, input pitch, output ready);
endinterface

interface ddrs_rsp_if;
   import ddrs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [PHASE_W-1:0]      phase;
   logic                    drogue_fire;
   logic                    main_fire;
   logic signed [ALT_W-1:0] peak_altitude;
   modport source (output valid, output phase, output drogue_fire, output main_fire,
                   output peak_altitude, input ready);
   modport sink (input valid, input phase, input drogue_fire, input main_fire,
                 input peak_altitude, output ready);
endinterface

// ----- sv/dual_deploy_recovery_sequencer.sv -----
// Top level of the dual deploy recovery sequencer.
// An accepted word goes through the input register and then the response register.
// Throughput: one word per cycle, set by both registers, unless rsp_ch stalls.
// Reset clears the flight phase, peak, descent count and valid flags at once.
// Configuration registers return to their default values on reset.
module dual_deploy_recovery_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   ddrs_req_if.sink                         req_ch,
   ddrs_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [ddrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ddrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ddrs_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      take;

   ddrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddrs_input_stage u_input (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .stage  (stage)
   );

   ddrs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .stage  (stage),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- sv/ddrs_csr.sv -----
// Configuration register file of the recovery sequencer.
module ddrs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ddrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ddrs_pkg::cfg_type                   cfg
);
   import ddrs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ARM_ALTITUDE:  cfg_in.arm_altitude  = csr_wdata;
            REG_PITCH_MIN:     cfg_in.pitch_min     = csr_wdata[PITCH_W-1:0];
            REG_PITCH_MAX:     cfg_in.pitch_max     = csr_wdata[PITCH_W-1:0];
            REG_DROP_MARGIN:   cfg_in.drop_margin   = csr_wdata[MARGIN_W-1:0];
            REG_CONFIRM_COUNT: cfg_in.confirm_count = csr_wdata[COUNT_W-1:0];
            REG_MAIN_ALTITUDE: cfg_in.main_altitude = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_altitude  <= RST_ARM_ALTITUDE;
         cfg_ff.pitch_min     <= RST_PITCH_MIN;
         cfg_ff.pitch_max     <= RST_PITCH_MAX;
         cfg_ff.drop_margin   <= RST_DROP_MARGIN;
         cfg_ff.confirm_count <= RST_CONFIRM_COUNT;
         cfg_ff.main_altitude <= RST_MAIN_ALTITUDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/ddrs_input_stage.sv -----
// Input register stage that holds one sample word until the core takes it.
module ddrs_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   ddrs_req_if.sink             req_ch,
   input  logic                 take,
   output ddrs_pkg::stage_type  stage
);
   import ddrs_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [ALT_W-1:0]   altitude_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic                      accept;

   assign req_ch.ready = !valid_ff || take;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         altitude_ff <= req_ch.altitude;
         pitch_ff    <= req_ch.pitch;
      end
   end

   assign stage.valid    = valid_ff;
   assign stage.altitude = altitude_ff;
   assign stage.pitch    = pitch_ff;

endmodule

// ----- sv/ddrs_core.sv -----
// Flight state, apogee detection logic and the response register.
module ddrs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  ddrs_pkg::cfg_type    cfg,
   input  ddrs_pkg::stage_type  stage,
   output logic                 take,
   ddrs_rsp_if.source           rsp_ch
);
   import ddrs_pkg::*;

   phase_type               phase_ff, phase_in;
   logic signed [ALT_W-1:0] peak_ff, peak_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]      rsp_phase_ff, rsp_phase_in;
   logic                    drogue_ff, drogue_in;
   logic                    main_ff, main_in;
   logic signed [ALT_W-1:0] rsp_peak_ff;

   logic                    armed;
   logic                    below;
   logic signed [ALT_W+1:0] threshold;

   assign take = stage.valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      peak_in = (stage.altitude > peak_ff) ? stage.altitude : peak_ff;
      armed = (stage.altitude > $signed({1'b0, cfg.arm_altitude}))
              && (stage.pitch >= cfg.pitch_min) && (stage.pitch <= cfg.pitch_max);
      threshold = $signed({{2{peak_in[ALT_W-1]}}, peak_in})
                  - $signed({6'b0, cfg.drop_margin});
      below = $signed({{2{stage.altitude[ALT_W-1]}}, stage.altitude}) < threshold;
      phase_in  = phase_ff;
      count_in  = count_ff;
      drogue_in = 1'b0;
      main_in   = 1'b0;
      case (phase_ff)
         ST_CLIMB: begin
            if (armed) begin
               if (below) begin
                  count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
               end else begin
                  count_in = '0;
               end
               if (count_in >= cfg.confirm_count) begin
                  phase_in  = ST_DESCENT;
                  drogue_in = 1'b1;
               end
            end
         end
         ST_DESCENT: begin
            if (stage.altitude < $signed({1'b0, cfg.main_altitude})) begin
               phase_in = ST_MAIN;
               main_in  = 1'b1;
            end
         end
         ST_MAIN: phase_in = ST_MAIN;
         default: phase_in = phase_ff;
      endcase
      case (phase_in)
         ST_CLIMB:   rsp_phase_in = PHASE_CODE_CLIMB;
         ST_DESCENT: rsp_phase_in = PHASE_CODE_DESCENT;
         ST_MAIN:    rsp_phase_in = PHASE_CODE_MAIN;
         default:    rsp_phase_in = PHASE_CODE_MAIN;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_CLIMB;
         peak_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            peak_ff  <= peak_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_phase_ff <= rsp_phase_in;
         drogue_ff    <= drogue_in;
         main_ff      <= main_in;
         rsp_peak_ff  <= peak_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.phase         = rsp_phase_ff;
   assign rsp_ch.drogue_fire   = drogue_ff;
   assign rsp_ch.main_fire     = main_ff;
   assign rsp_ch.peak_altitude = rsp_peak_ff;

endmodule

// ----- sv/ddrs_checker.sv -----
// Port level assertions of the recovery sequencer and their bind.
module ddrs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ddrs_pkg::PHASE_W-1:0]  rsp_phase,
   input logic                          rsp_drogue_fire,
   input logic                          rsp_main_fire
);
   import ddrs_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_drogue_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drogue_fire |-> rsp_phase == PHASE_CODE_DESCENT)
      else $error("drogue fired outside descent entry");

   a_main_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_main_fire |-> rsp_phase == PHASE_CODE_MAIN && !rsp_drogue_fire)
      else $error("main fired outside main entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
      && $stable(rsp_drogue_fire) && $stable(rsp_main_fire))
      else $error("stalled response word changed");

endmodule

bind dual_deploy_recovery_sequencer ddrs_checker u_ddrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_phase       (rsp_ch.phase),
   .rsp_drogue_fire (rsp_ch.drogue_fire),
   .rsp_main_fire   (rsp_ch.main_fire)
);

// ----- test/dual_deploy_recovery_sequencer_test.sv -----
// Self-checking testbench for the dual deploy recovery sequencer: directed and random flights.
module dual_deploy_recovery_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ddrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ALT_TOP        = 524287;
   localparam int ALT_BOTTOM     = -524288;
   localparam int PLAN_ROWS      = 21;

   typedef struct packed {
      logic [PHASE_W-1:0]      phase;
      logic                    drogue_fire;
      logic                    main_fire;
      logic signed [ALT_W-1:0] peak_altitude;
   } flight_report_type;

   typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      int                     altitude;
      int                     pitch;
      logic [CSR_IDX_W-1:0]   reg_index;
      int                     reg_value;
      bit                     typed;
      int                     peak;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ddrs_req_if req_ch ();
   ddrs_rsp_if rsp_ch ();

   dual_deploy_recovery_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted configuration and flight state.
   logic [CFG_ALT_W-1:0]      arm_alt_cfg   = RST_ARM_ALTITUDE;
   logic signed [PITCH_W-1:0] pitch_lo_cfg  = RST_PITCH_MIN;
   logic signed [PITCH_W-1:0] pitch_hi_cfg  = RST_PITCH_MAX;
   logic [MARGIN_W-1:0]       margin_cfg    = RST_DROP_MARGIN;
   logic [COUNT_W-1:0]        confirm_cfg   = RST_CONFIRM_COUNT;
   logic [CFG_ALT_W-1:0]      main_alt_cfg  = RST_MAIN_ALTITUDE;
   logic [PHASE_W-1:0]        flight_phase  = PHASE_CODE_CLIMB;
   int                        peak_height   = 0;
   logic [COUNT_W-1:0]        descent_count = '0;

   flight_report_type awaited_reports [$];
   flight_report_type seen_report;
   flight_report_type due_report;
   flight_report_type new_report;
   int             failures    = 0;
   int             idle_cycles = 0;
   bit             no_idle     = 1'b0;
   bit             typed_flag  = 1'b0;
   int             typed_peak  = 0;

   plan_row_type opening_plan [PLAN_ROWS] = '{
      '{ROW_SAMPLE,   -5000,     0, REG_ARM_ALTITUDE,      0, 1'b1,     0},
      '{ROW_SAMPLE, -524288, -2048, REG_ARM_ALTITUDE,      0, 1'b1,     0},
      '{ROW_SAMPLE,       0,  2047, REG_ARM_ALTITUDE,      0, 1'b1,     0},
      '{ROW_SAMPLE,   10000,   900, REG_ARM_ALTITUDE,      0, 1'b1, 10000},
      '{ROW_SAMPLE,   20000,  1800, REG_ARM_ALTITUDE,      0, 1'b1, 20000},
      '{ROW_SAMPLE,   30000,   600, REG_ARM_ALTITUDE,      0, 1'b1, 30000},
      '{ROW_SAMPLE,   29970,  1200, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   29969,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   25000,   599, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   25000,  1201, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   25000,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   30001,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   29000,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_WRITE,        0,     0, REG_PITCH_MIN,      1201, 1'b0,     0},
      '{ROW_SAMPLE,   20000,  1200, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_SAMPLE,   20000,  1201, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_WRITE,        0,     0, REG_PITCH_MIN,       600, 1'b0,     0},
      '{ROW_SAMPLE,   20000,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_WRITE,        0,     0, REG_DROP_MARGIN,   65535, 1'b0,     0},
      '{ROW_SAMPLE,   20000,   900, REG_ARM_ALTITUDE,      0, 1'b0,     0},
      '{ROW_WRITE,        0,     0, REG_DROP_MARGIN,      30, 1'b0,     0}
   };

   always #1 clock = ~clock;

   function automatic int clamp_alt(input int value);
      if (value > ALT_TOP) begin
         return ALT_TOP;
      end
      if (value < ALT_BOTTOM) begin
         return ALT_BOTTOM;
      end
      return value;
   endfunction

   function automatic int any_alt();
      return int'($urandom_range(0, 1048575)) + ALT_BOTTOM;
   endfunction

   function automatic int any_pitch();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_ARM_ALTITUDE:  arm_alt_cfg  = value[CFG_ALT_W-1:0];
         REG_PITCH_MIN:     pitch_lo_cfg = value[PITCH_W-1:0];
         REG_PITCH_MAX:     pitch_hi_cfg = value[PITCH_W-1:0];
         REG_DROP_MARGIN:   margin_cfg   = value[MARGIN_W-1:0];
         REG_CONFIRM_COUNT: confirm_cfg  = value[COUNT_W-1:0];
         REG_MAIN_ALTITUDE: main_alt_cfg = value[CFG_ALT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic flight_report_type advance_flight(input int alt, input int pitch);
      flight_report_type report;
      bit             armed;
      report = '0;
      if (alt > peak_height) begin
         peak_height = alt;
      end
      case (flight_phase)
         PHASE_CODE_CLIMB: begin
            armed = alt > int'(arm_alt_cfg) && pitch >= int'(pitch_lo_cfg) &&
                    pitch <= int'(pitch_hi_cfg);
            if (armed) begin
               if (alt < peak_height - int'(margin_cfg)) begin
                  if (descent_count != COUNT_MAX) begin
                     descent_count = descent_count + 1'b1;
                  end
               end else begin
                  descent_count = '0;
               end
               if (descent_count >= confirm_cfg) begin
                  flight_phase = PHASE_CODE_DESCENT;
                  report.drogue_fire = 1'b1;
               end
            end
         end
         PHASE_CODE_DESCENT: begin
            if (alt < int'(main_alt_cfg)) begin
               flight_phase = PHASE_CODE_MAIN;
               report.main_fire = 1'b1;
            end
         end
         default: ;
      endcase
      report.phase = flight_phase;
      report.peak_altitude = peak_height[ALT_W-1:0];
      return report;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_report = '{rsp_ch.phase, rsp_ch.drogue_fire, rsp_ch.main_fire,
                            rsp_ch.peak_altitude};
            if (awaited_reports.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected response word: phase %0d drogue %0b main %0b peak %0d",
                           seen_report.phase, seen_report.drogue_fire,
                           seen_report.main_fire, seen_report.peak_altitude);
               end
            end else begin
               due_report = awaited_reports.pop_front();
               if (seen_report.phase !== due_report.phase ||
                   seen_report.drogue_fire !== due_report.drogue_fire ||
                   seen_report.main_fire !== due_report.main_fire ||
                   seen_report.peak_altitude !== due_report.peak_altitude) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch: expected phase %0d drogue %0b main %0b peak %0d",
                              due_report.phase, due_report.drogue_fire,
                              due_report.main_fire, due_report.peak_altitude);
                     $display("          actual   phase %0d drogue %0b main %0b peak %0d",
                              seen_report.phase, seen_report.drogue_fire,
                              seen_report.main_fire, seen_report.peak_altitude);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            new_report = advance_flight(int'(req_ch.altitude), int'(req_ch.pitch));
            if (typed_flag) begin
               new_report = '{PHASE_CODE_CLIMB, 1'b0, 1'b0, typed_peak[ALT_W-1:0]};
            end
            awaited_reports.push_back(new_report);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_ch.valid) begin
               break;
            end
         end
         @(negedge clock);
      end
   end

   task automatic send_sample(input int alt, input int pitch, input bit typed,
                              input int peak);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (!no_idle && $urandom_range(0, 63) == 0) begin
         req_ch.valid = 1'b0;
         while (awaited_reports.size() != 0) begin
            @(negedge clock);
         end
      end
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_flag = typed;
      typed_peak = peak;
      req_ch.altitude = alt[ALT_W-1:0];
      req_ch.pitch = pitch[PITCH_W-1:0];
      req_ch.valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ch.ready) begin
            break;
         end
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (awaited_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_DATA_W-1:0];
      apply_register(index, value[CSR_DATA_W-1:0]);
      @(negedge clock);
   endtask

   task automatic configure(input int arm, input int pmin, input int pmax,
                            input int margin, input int confirm, input int main_alt);
      settle();
      put_reg(REG_ARM_ALTITUDE, arm);
      put_reg(REG_PITCH_MIN, pmin);
      put_reg(REG_PITCH_MAX, pmax);
      put_reg(REG_DROP_MARGIN, margin);
      put_reg(REG_CONFIRM_COUNT, confirm);
      put_reg(REG_MAIN_ALTITUDE, main_alt);
      csr_we = 1'b0;
   endtask

   // Climb samples mostly sit around the current peak so the descent counter both
   // advances and clears, with some wild samples mixed in.
   task automatic fly_climb(input int count);
      int alt;
      int pitch;
      int roll;
      int lo;
      int hi;
      int margin;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 9);
         lo = int'(pitch_lo_cfg);
         hi = int'(pitch_hi_cfg);
         margin = int'(margin_cfg);
         pitch = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : any_pitch();
         case (roll)
            0: begin
               alt = any_alt();
               pitch = any_pitch();
            end
            1, 2: alt = peak_height - int'($urandom_range(0, margin));
            8: begin
               alt = peak_height - margin - 1 - int'($urandom_range(0, 20000));
               pitch = any_pitch();
            end
            9: alt = peak_height + int'($urandom_range(1, 1000));
            default: alt = peak_height - margin - 1 - int'($urandom_range(0, 20000));
         endcase
         send_sample(clamp_alt(alt), pitch, 1'b0, 0);
      end
   endtask

   task automatic fly_descent(input int count);
      int floor_alt;
      int alt;
      int roll;
      for (int n = 0; n < count; n++) begin
         floor_alt = int'(main_alt_cfg);
         roll = $urandom_range(0, 4);
         case (roll)
            0: alt = floor_alt + int'($urandom_range(0, ALT_TOP - floor_alt));
            1: alt = floor_alt;
            default: alt = floor_alt + int'($urandom_range(0, 100000));
         endcase
         send_sample(clamp_alt(alt), any_pitch(), 1'b0, 0);
      end
   endtask

   task automatic fly_spent(input int count);
      int alt;
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: alt = ALT_TOP;
            1: alt = ALT_BOTTOM;
            default: alt = any_alt();
         endcase
         send_sample(alt, any_pitch(), 1'b0, 0);
      end
   endtask

   initial begin
      int a;
      int b;
      int tries;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_ARM_ALTITUDE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.altitude = '0;
      req_ch.pitch = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      no_idle = 1'b0;
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (opening_plan[r].kind == ROW_WRITE) begin
            settle();
            put_reg(opening_plan[r].reg_index, opening_plan[r].reg_value);
            csr_we = 1'b0;
         end else begin
            send_sample(opening_plan[r].altitude, opening_plan[r].pitch,
                        opening_plan[r].typed, opening_plan[r].peak);
         end
      end

      no_idle = ($urandom_range(0, 3) == 0);
      configure(0, -2048, 2047, 0, 255, 0);
      fly_climb(250);

      no_idle = 1'b1;
      configure(ALT_TOP, 2047, -2048, 65535, 0, 0);
      fly_climb(200);

      no_idle = ($urandom_range(0, 3) == 0);
      a = int'($urandom_range(0, 3600)) - 1800;
      b = int'($urandom_range(0, 3600)) - 1800;
      configure($urandom_range(0, 400000), (a < b) ? a : b, (a < b) ? b : a,
                $urandom_range(0, 2000), $urandom_range(200, 255),
                $urandom_range(0, 500000));
      fly_climb(300);

      no_idle = ($urandom_range(0, 3) == 0);
      configure(0, $urandom_range(1, 2047), int'($urandom_range(0, 2000)) - 2048,
                $urandom_range(0, 65535), 1, $urandom_range(0, 500000));
      fly_climb(150);

      // Zero confirm count: the first armed sample fires the drogue.
      no_idle = ($urandom_range(0, 3) == 0);
      configure(0, -2048, 2047, 65535, 0, 0);
      tries = 0;
      while (flight_phase == PHASE_CODE_CLIMB && tries < 10) begin
         send_sample(5 + tries, 0, 1'b0, 0);
         tries++;
      end
      fly_descent(100);

      no_idle = ($urandom_range(0, 3) == 0);
      configure($urandom_range(0, 500000), any_pitch(), any_pitch(),
                $urandom_range(0, 65535), $urandom_range(0, 255),
                $urandom_range(1, 400000));
      fly_descent(200);

      configure(int'(arm_alt_cfg), int'(pitch_lo_cfg), int'(pitch_hi_cfg),
                int'(margin_cfg), int'(confirm_cfg), ALT_TOP);
      send_sample(ALT_TOP, 0, 1'b0, 0);
      send_sample(ALT_TOP - 1, 0, 1'b0, 0);

      no_idle = ($urandom_range(0, 3) == 0);
      fly_spent(150);

      // Upper data bits beyond each register's width must be ignored.
      no_idle = ($urandom_range(0, 3) == 0);
      configure($urandom_range(0, ALT_TOP),
                (int'($urandom_range(0, 127)) << 12) | (any_pitch() & 12'hFFF),
                (int'($urandom_range(0, 127)) << 12) | (any_pitch() & 12'hFFF),
                (int'($urandom_range(0, 7)) << 16) | int'($urandom_range(0, 65535)),
                (int'($urandom_range(0, 2047)) << 8) | int'($urandom_range(0, 255)),
                $urandom_range(0, ALT_TOP));
      fly_spent(200);

      req_ch.valid = 1'b0;
      while (awaited_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (failures == 0 && awaited_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
